@@ hdl/sko_pkg.sv @@
// Shared types, codes and constants of the scaled keyed overlay core.
// Used by every module in this folder; depends on nothing.
package sko_pkg;

  localparam int unsigned SKO_MAX_WIDTH       = 256;
  localparam int unsigned SKO_MAX_HEIGHT      = 256;
  localparam int unsigned SKO_BYTES_PER_PIXEL = 4;
  localparam int unsigned SKO_PIXEL_W         = 8 * SKO_BYTES_PER_PIXEL;

  localparam int unsigned SKO_COORD_W    = 8;
  localparam int unsigned SKO_DIM_W      = 9;
  localparam int unsigned SKO_SCALE_W    = 12;
  localparam int unsigned SKO_SIZE_W     = SKO_DIM_W + SKO_SCALE_W - 8;
  localparam int unsigned SKO_CFG_IDX_W  = 3;
  localparam int unsigned SKO_CFG_DATA_W = 12;

  localparam int unsigned SKO_DIVIDEND_W = SKO_COORD_W + 8;
  localparam int unsigned SKO_DIV_STEPS  = 4;
  localparam int unsigned SKO_DIV_LANES  = 2;

  typedef enum logic [SKO_CFG_IDX_W-1:0] {
    CFG_BACK_WIDTH  = 3'd0,
    CFG_BACK_HEIGHT = 3'd1,
    CFG_FORE_WIDTH  = 3'd2,
    CFG_FORE_HEIGHT = 3'd3,
    CFG_SCALE       = 3'd4,
    CFG_PLACE_ROW   = 3'd5,
    CFG_PLACE_COL   = 3'd6
  } sko_cfg_e;

  typedef enum logic [1:0] {
    REQ_WR_BACK = 2'd0,
    REQ_WR_FORE = 2'd1,
    REQ_READ    = 2'd2
  } sko_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FIT   = 2'd1,
    ST_RANGE = 2'd2
  } sko_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIT,
    S_BACK,
    S_DIV,
    S_FORE,
    S_DONE
  } sko_state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [SKO_COORD_W-1:0] pix_row;
    logic [SKO_COORD_W-1:0] pix_col;
    logic [SKO_PIXEL_W-1:0] pix_value;
  } sko_req_t;

  typedef struct packed {
    logic [SKO_PIXEL_W-1:0] out_pixel;
    logic [1:0]             status;
  } sko_res_t;

endpackage

@@ hdl/sko_pixel_ram.sv @@
// Single-port synchronous pixel memory with a registered read port.
// Depends on sko_pkg for the pixel width.
module sko_pixel_ram #(
  parameter int unsigned DEPTH = sko_pkg::SKO_MAX_WIDTH * sko_pkg::SKO_MAX_HEIGHT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [sko_pkg::SKO_PIXEL_W-1:0] wdata_i,
  output logic [sko_pkg::SKO_PIXEL_W-1:0] rdata_o
);
  import sko_pkg::*;

  logic [SKO_PIXEL_W-1:0] mem_q [DEPTH];
  logic [SKO_PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sko_divider.sv @@
// Two-lane restoring divider that retires four quotient bits per cycle.
// Depends on sko_pkg for the operand widths and the step count.
module sko_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [sko_pkg::SKO_DIV_LANES-1:0][sko_pkg::SKO_DIVIDEND_W-1:0] dividend_i,
  input  logic [sko_pkg::SKO_SCALE_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic [sko_pkg::SKO_DIV_LANES-1:0][sko_pkg::SKO_DIVIDEND_W-1:0] quot_o
);
  import sko_pkg::*;

  localparam int unsigned DW     = SKO_DIVIDEND_W;
  localparam int unsigned VW     = SKO_SCALE_W;
  localparam int unsigned CYCLES = DW / SKO_DIV_STEPS;
  localparam int unsigned CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [SKO_DIV_LANES-1:0][DW-1:0]  quo_q, quo_d;
  logic [SKO_DIV_LANES-1:0][VW-1:0]  rem_q, rem_d;

  always_comb begin
    logic [VW:0]   trial;
    logic [VW-1:0] r;
    logic [DW-1:0] q;
    trial  = '0;
    r      = '0;
    q      = '0;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < SKO_DIV_LANES; l++) begin
        r = rem_q[l];
        q = quo_q[l];
        for (int s = 0; s < SKO_DIV_STEPS; s++) begin
          trial = {r, q[DW-1]};
          if (trial >= {1'b0, divisor_i}) begin
            r = VW'(trial - {1'b0, divisor_i});
            q = {q[DW-2:0], 1'b1};
          end else begin
            r = trial[VW-1:0];
            q = {q[DW-2:0], 1'b0};
          end
        end
        rem_d[l] = r;
        quo_d[l] = q;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/scaled_keyed_overlay_core.sv @@
// Top level of the scaled keyed overlay: configuration, sequencer and output register.
// Depends on sko_pkg, sko_pixel_ram and sko_divider.

// The core holds a background and a foreground image, each in a single-port memory of
// MAX_WIDTH * MAX_HEIGHT pixels addressed row * MAX_WIDTH + col, and handles one beat at a
// time: a write runs EXEC then DONE; a read runs EXEC and FIT, where an error ends it,
// then BACK outside the placed window or DIV inside it, where the divider forms the
// 16-bit quotient at four bits per cycle as the background is read, then FORE if the
// source is in the foreground. A finished result sits in the output register while the
// next beat is accepted and worked on; a beat that finishes while that result still waits
// is held until the result is taken. Memory contents are undefined until written;
// configuration writes are always accepted, act at once, and belong between beats.
module scaled_keyed_overlay_core #(
  parameter int unsigned MAX_WIDTH  = sko_pkg::SKO_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sko_pkg::SKO_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sko_pkg::sko_req_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sko_pkg::sko_res_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sko_pkg::SKO_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sko_pkg::SKO_CFG_DATA_W-1:0] cfg_data_i
);
  import sko_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [SKO_DIM_W-1:0] DIM_CAP = {SKO_DIM_W{1'b1}};
  localparam logic [SKO_DIM_W-1:0] MAX_W_DIM =
      (MAX_WIDTH > DIM_CAP) ? DIM_CAP : SKO_DIM_W'(MAX_WIDTH);
  localparam logic [SKO_DIM_W-1:0] MAX_H_DIM =
      (MAX_HEIGHT > DIM_CAP) ? DIM_CAP : SKO_DIM_W'(MAX_HEIGHT);
  localparam int unsigned PROD_W = SKO_DIM_W + SKO_SCALE_W;

  function automatic logic [AW-1:0] addr_of(input logic [SKO_DIM_W-1:0] r,
                                            input logic [SKO_DIM_W-1:0] c);
    return AW'(r) * ROW_STRIDE + AW'(c);
  endfunction

  logic [SKO_DIM_W-1:0]   back_width_q, back_height_q, fore_width_q, fore_height_q;
  logic [SKO_SCALE_W-1:0] scale_q;
  logic [SKO_COORD_W-1:0] place_row_q, place_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_width_q  <= SKO_DIM_W'(256);
      back_height_q <= SKO_DIM_W'(256);
      fore_width_q  <= SKO_DIM_W'(256);
      fore_height_q <= SKO_DIM_W'(256);
      scale_q       <= SKO_SCALE_W'(256);
      place_row_q   <= '0;
      place_col_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BACK_WIDTH:  back_width_q  <= cfg_data_i[SKO_DIM_W-1:0];
        CFG_BACK_HEIGHT: back_height_q <= cfg_data_i[SKO_DIM_W-1:0];
        CFG_FORE_WIDTH:  fore_width_q  <= cfg_data_i[SKO_DIM_W-1:0];
        CFG_FORE_HEIGHT: fore_height_q <= cfg_data_i[SKO_DIM_W-1:0];
        CFG_SCALE:       scale_q       <= cfg_data_i[SKO_SCALE_W-1:0];
        CFG_PLACE_ROW:   place_row_q   <= cfg_data_i[SKO_COORD_W-1:0];
        CFG_PLACE_COL:   place_col_q   <= cfg_data_i[SKO_COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [SKO_DIM_W-1:0] bw, bh, fw, fh;
  assign bw = (back_width_q  > MAX_W_DIM) ? MAX_W_DIM : back_width_q;
  assign bh = (back_height_q > MAX_H_DIM) ? MAX_H_DIM : back_height_q;
  assign fw = (fore_width_q  > MAX_W_DIM) ? MAX_W_DIM : fore_width_q;
  assign fh = (fore_height_q > MAX_H_DIM) ? MAX_H_DIM : fore_height_q;

  sko_state_e state_q, state_d;
  sko_req_t   item_q;
  sko_res_t   res_q, res_d, out_q;
  logic       out_valid_q, out_valid_d;
  logic [SKO_SIZE_W-1:0] sw_q, sw_d, sh_q, sh_d;

  logic item_load, out_load;
  logic back_we, back_re, fore_we, fore_re;
  logic div_start, div_done;
  logic [SKO_DIV_LANES-1:0][SKO_DIVIDEND_W-1:0] div_num, div_quot;
  logic [SKO_PIXEL_W-1:0] back_rdata, fore_rdata;
  logic [AW-1:0] back_addr, fore_addr;

  logic [SKO_DIM_W-1:0]   row9, col9;
  logic [SKO_COORD_W-1:0] dy, dx;
  logic [PROD_W-1:0]      prod_w, prod_h;
  logic                   in_back, in_fore, fit_err, in_win, src_ok;

  assign row9    = {1'b0, item_q.pix_row};
  assign col9    = {1'b0, item_q.pix_col};
  assign in_back = (row9 < bh) && (col9 < bw);
  assign in_fore = (row9 < fh) && (col9 < fw);
  assign prod_w  = PROD_W'(fw) * PROD_W'(scale_q);
  assign prod_h  = PROD_W'(fh) * PROD_W'(scale_q);
  assign fit_err = ((SKO_SIZE_W + 1)'(place_col_q) + (SKO_SIZE_W + 1)'(sw_q)
                    > (SKO_SIZE_W + 1)'(bw)) ||
                   ((SKO_SIZE_W + 1)'(place_row_q) + (SKO_SIZE_W + 1)'(sh_q)
                    > (SKO_SIZE_W + 1)'(bh));
  assign dy      = item_q.pix_row - place_row_q;
  assign dx      = item_q.pix_col - place_col_q;
  assign in_win  = (item_q.pix_row >= place_row_q) && (item_q.pix_col >= place_col_q) &&
                   (SKO_SIZE_W'(dy) < sh_q) && (SKO_SIZE_W'(dx) < sw_q) && (scale_q != '0);
  assign div_num[0] = {dy, 8'h00};
  assign div_num[1] = {dx, 8'h00};
  assign src_ok  = (div_quot[0] < SKO_DIVIDEND_W'(fh)) && (div_quot[1] < SKO_DIVIDEND_W'(fw));

  assign back_addr = addr_of(row9, col9);
  assign fore_addr = fore_re ? addr_of(div_quot[0][SKO_DIM_W-1:0], div_quot[1][SKO_DIM_W-1:0])
                             : addr_of(row9, col9);

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    sw_d      = sw_q;
    sh_d      = sh_q;
    item_load = 1'b0;
    out_load  = 1'b0;
    back_we   = 1'b0;
    back_re   = 1'b0;
    fore_we   = 1'b0;
    fore_re   = 1'b0;
    div_start = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_load = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '{out_pixel: '0, status: ST_OK};
        state_d = S_DONE;
        unique case (item_q.req_type)
          REQ_WR_BACK: begin
            if (in_back) begin
              back_we = 1'b1;
            end else begin
              res_d.status = ST_RANGE;
            end
          end
          REQ_WR_FORE: begin
            if (in_fore) begin
              fore_we = 1'b1;
            end else begin
              res_d.status = ST_RANGE;
            end
          end
          REQ_READ: begin
            sw_d    = prod_w[PROD_W-1:8];
            sh_d    = prod_h[PROD_W-1:8];
            state_d = S_FIT;
          end
          default: ;
        endcase
      end
      S_FIT: begin
        if (fit_err) begin
          res_d.status = ST_FIT;
          state_d      = S_DONE;
        end else if (!in_back) begin
          res_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          back_re = 1'b1;
          if (in_win) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            state_d = S_BACK;
          end
        end
      end
      S_BACK: begin
        res_d.out_pixel = back_rdata;
        state_d         = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          if (src_ok) begin
            fore_re = 1'b1;
            state_d = S_FORE;
          end else begin
            res_d.out_pixel = back_rdata;
            state_d         = S_DONE;
          end
        end
      end
      S_FORE: begin
        res_d.out_pixel = (fore_rdata[7:0] != 8'h00) ? fore_rdata : back_rdata;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    res_q <= res_d;
    sw_q  <= sw_d;
    sh_q  <= sh_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sko_pixel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_we),
    .re_i    (back_re),
    .addr_i  (back_addr),
    .wdata_i (item_q.pix_value),
    .rdata_o (back_rdata)
  );

  sko_pixel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fore_ram (
    .clk_i   (clk_i),
    .we_i    (fore_we),
    .re_i    (fore_re),
    .addr_i  (fore_addr),
    .wdata_i (item_q.pix_value),
    .rdata_o (fore_rdata)
  );

  sko_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (scale_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted beat did not enter execution");

  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_we || fore_we |-> state_q == S_EXEC)
    else $error("memory write outside execution");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished while sequencer was not waiting");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented without a finished beat");

endmodule
